### rtl/block_cache_slot_manager_core_assert.svh
// assertion macros for the block cache slot manager checker
// no dependencies; included by the checker file
`ifndef BLOCK_CACHE_SLOT_MANAGER_CORE_ASSERT_SVH
`define BLOCK_CACHE_SLOT_MANAGER_CORE_ASSERT_SVH

// generic clocked property with synchronous active-low reset
`define BCSM_ASSERT_PROP(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// expression that must never be true
`define BCSM_ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
  `BCSM_ASSERT_PROP(lbl, clk, rstn, (!(expr)), msg)

`endif

### rtl/bcsm_pkg.sv
// shared types, constants and helpers for the block cache slot manager
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package bcsm_pkg;

  localparam int ENTRIES = 32;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int BLK_W   = 32;
  localparam int SLOT_W  = 5;

  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_FLUSH  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPD,
    ST_FLUSH,
    ST_DONE
  } state_t;

  typedef struct packed {
    op_t              opcode;
    logic [BLK_W-1:0] block_number;
    logic             is_write;
  } in_word_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              hit;
    logic              writeback_needed;
    logic [BLK_W-1:0]  writeback_block;
    logic              last;
  } out_word_t;

  typedef struct packed {
    logic             valid;
    logic             dirty;
    logic [BLK_W-1:0] tag;
  } cell_data_t;

  typedef struct packed {
    logic capture;
    logic shift;
    logic load;
    logic mark_dirty;
  } cell_ctrl_t;

  typedef struct packed {
    logic             hit;
    logic             free_found;
    logic [IDX_W-1:0] hit_idx;
    logic [IDX_W-1:0] free_idx;
  } pick_t;

  function automatic logic [SLOT_W-1:0] to_slot(input logic [IDX_W-1:0] idx);
    logic [IDX_W+SLOT_W-1:0] wide;
    wide = {{SLOT_W{1'b0}}, idx};
    return wide[SLOT_W-1:0];
  endfunction

endpackage

`default_nettype wire

### rtl/bcsm_cell.sv
// one slot of the tag row: valid, dirty, tag and a registered tag match
// depends on bcsm_pkg
`timescale 1ns / 1ps
`default_nettype none

module bcsm_cell
  import bcsm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  cell_ctrl_t       ctrl,
  input  logic [BLK_W-1:0] cmp_block,
  input  logic [BLK_W-1:0] ld_block,
  input  logic             ld_dirty,
  input  cell_data_t       nbr_in,
  output cell_data_t       data,
  output logic             match
);

  logic             valid_r;
  logic             dirty_r;
  logic [BLK_W-1:0] tag_r;
  logic             match_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      dirty_r <= 1'b0;
      match_r <= 1'b0;
    end else begin
      if (ctrl.shift) begin
        valid_r <= nbr_in.valid;
        dirty_r <= nbr_in.dirty;
      end else if (ctrl.load) begin
        valid_r <= 1'b1;
        dirty_r <= ld_dirty;
      end else if (ctrl.mark_dirty) begin
        dirty_r <= 1'b1;
      end
      if (ctrl.capture) begin
        match_r <= valid_r && (tag_r == cmp_block);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      tag_r <= nbr_in.tag;
    end else if (ctrl.load) begin
      tag_r <= ld_block;
    end
  end

  assign data  = '{valid: valid_r, dirty: dirty_r, tag: tag_r};
  assign match = match_r;

endmodule

`default_nettype wire

### rtl/bcsm_pick.sv
// slot selection: encodes the hit slot and finds the lowest free slot
// depends on bcsm_pkg
`timescale 1ns / 1ps
`default_nettype none

module bcsm_pick
  import bcsm_pkg::*;
(
  input  logic [ENTRIES-1:0] match_vec,
  input  logic [ENTRIES-1:0] valid_vec,
  output pick_t              pick
);

  logic [IDX_W-1:0] hit_idx;
  logic [IDX_W-1:0] free_idx;
  logic             free_found;

  // at most one valid slot matches, so an or of indexes encodes it
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (match_vec[i]) begin
        hit_idx = hit_idx | IDX_W'(i);
      end
    end
  end

  always_comb begin
    free_idx   = '0;
    free_found = 1'b0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid_vec[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  assign pick = '{hit: |match_vec, free_found: free_found,
                  hit_idx: hit_idx, free_idx: free_idx};

endmodule

`default_nettype wire

### rtl/block_cache_slot_manager_core.sv
// top level of the block cache slot manager: cell row, slot pick, control
// depends on bcsm_pkg, bcsm_cell, bcsm_pick
//
//   channel  ports                      handshake
//   input    start, busy, in_word       taken when start && !busy
//   result   out_valid, out_word        one-cycle strobe, no back-pressure
//
// lookup: tags compare in every cell at the accepting edge, the
//   next cycle picks the slot and updates the row
// flush: the row shifts toward slot 0 once per cycle, reporting
//   dirty slots, then ST_DONE gives the done word
// reset clears valid and dirty; tags are left as they are
// results cannot be stalled; busy is high only while a word is in work
`timescale 1ns / 1ps
`default_nettype none

module block_cache_slot_manager_core
  import bcsm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  in_word_t  in_word,
  output logic      busy,
  output logic      out_valid,
  output out_word_t out_word
);

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] vp_r, vp_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic [BLK_W-1:0] req_block_r;
  logic             req_wr_r;
  logic             out_valid_r, out_valid_nxt;
  out_word_t        out_word_r, out_word_nxt;

  cell_ctrl_t       ctrl [ENTRIES];
  cell_data_t       data [ENTRIES];
  logic [ENTRIES-1:0] match_vec;
  logic [ENTRIES-1:0] valid_vec;
  pick_t            pick;
  logic             accept;
  logic [IDX_W-1:0] chosen;
  logic             evict;

  assign accept = start && (state_r == ST_IDLE);

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    cell_data_t nbr;
    if (g == ENTRIES - 1) begin : g_tail
      assign nbr = '0;
    end else begin : g_body
      assign nbr = data[g+1];
    end

    bcsm_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl[g]),
      .cmp_block (in_word.block_number),
      .ld_block  (req_block_r),
      .ld_dirty  (req_wr_r),
      .nbr_in    (nbr),
      .data      (data[g]),
      .match     (match_vec[g])
    );

    assign valid_vec[g] = data[g].valid;
  end

  bcsm_pick u_pick (
    .match_vec (match_vec),
    .valid_vec (valid_vec),
    .pick      (pick)
  );

  assign evict  = !pick.free_found;
  assign chosen = pick.free_found ? pick.free_idx : vp_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = (in_word.opcode == OP_FLUSH) ? ST_FLUSH : ST_UPD;
        end
      end
      ST_UPD:   state_nxt = ST_IDLE;
      ST_FLUSH: begin
        if (cnt_r == IDX_W'(ENTRIES - 1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // outputs and row control
  always_comb begin
    vp_nxt        = vp_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = 1'b0;
    out_word_nxt  = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      ctrl[i] = '{capture: accept, shift: 1'b0, load: 1'b0, mark_dirty: 1'b0};
    end
    case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
      end
      ST_UPD: begin
        out_valid_nxt     = 1'b1;
        out_word_nxt.last = 1'b1;
        if (pick.hit) begin
          out_word_nxt.slot = to_slot(pick.hit_idx);
          out_word_nxt.hit  = 1'b1;
          for (int i = 0; i < ENTRIES; i++) begin
            ctrl[i].mark_dirty = req_wr_r && (IDX_W'(i) == pick.hit_idx);
          end
        end else begin
          out_word_nxt.slot = to_slot(chosen);
          for (int i = 0; i < ENTRIES; i++) begin
            ctrl[i].load = (IDX_W'(i) == chosen);
          end
          if (evict) begin
            vp_nxt = (vp_r == IDX_W'(ENTRIES - 1)) ? '0 : vp_r + 1'b1;
            if (data[vp_r].dirty) begin
              out_word_nxt.writeback_needed = 1'b1;
              out_word_nxt.writeback_block  = data[vp_r].tag;
            end
          end
        end
      end
      ST_FLUSH: begin
        for (int i = 0; i < ENTRIES; i++) begin
          ctrl[i].shift = 1'b1;
        end
        cnt_nxt = cnt_r + 1'b1;
        if (data[0].valid && data[0].dirty) begin
          out_valid_nxt                 = 1'b1;
          out_word_nxt.slot             = to_slot(cnt_r);
          out_word_nxt.writeback_needed = 1'b1;
          out_word_nxt.writeback_block  = data[0].tag;
        end
      end
      ST_DONE: begin
        out_valid_nxt     = 1'b1;
        out_word_nxt.last = 1'b1;
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      vp_r        <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      vp_r        <= vp_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
    if (accept) begin
      req_block_r <= in_word.block_number;
      req_wr_r    <= in_word.is_write;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

`default_nettype wire

### rtl/bcsm_checker.sv
// port-level checker for the block cache slot manager, bound to the top
// depends on bcsm_pkg and block_cache_slot_manager_core_assert.svh
`timescale 1ns / 1ps
`default_nettype none

`include "block_cache_slot_manager_core_assert.svh"

module bcsm_checker
  import bcsm_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input in_word_t  in_word,
  input logic      busy,
  input logic      out_valid,
  input out_word_t out_word
);

  // no result in the cycle after a word is taken
  `BCSM_ASSERT_PROP(a_no_out_after_accept, clk, rst_n, ((start && !busy) |=> !out_valid), "result right after accept")

  // a lookup answers with a last word through ST_UPD and the output register after it is taken
  `BCSM_ASSERT_PROP(a_lookup_latency, clk, rst_n, ((start && !busy && (in_word.opcode == OP_LOOKUP)) |-> ##2 (out_valid && out_word.last)), "lookup result missing")

  `BCSM_ASSERT_NEVER(a_hit_with_wb, clk, rst_n, (out_valid && out_word.hit && out_word.writeback_needed), "hit with write-back")

  `BCSM_ASSERT_NEVER(a_idle_not_last, clk, rst_n, (out_valid && !busy && !out_word.last), "final result without last")

endmodule

bind block_cache_slot_manager_core bcsm_checker u_bcsm_checker (.*);

`default_nettype wire

### dv/bcsm_slot_checker.sv
// checker for the block cache slot manager: tracks slot tags, predicts each result word
// and compares it with the observed output words; depends on bcsm_pkg
`timescale 1ns / 1ps

module bcsm_slot_checker
  import bcsm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      busy,
  input  in_word_t  in_word,
  input  logic      out_valid,
  input  out_word_t out_word,
  output int        mismatches,
  output int        outstanding
);

  logic             line_valid [ENTRIES];
  logic             line_dirty [ENTRIES];
  logic [BLK_W-1:0] line_tag   [ENTRIES];
  int               evict_ptr;
  out_word_t        expected_words [$];

  function automatic out_word_t make_result(int idx, logic hit, logic wb,
                                            logic [BLK_W-1:0] blk, logic last);
    out_word_t r;
    r.slot             = idx[SLOT_W-1:0];
    r.hit              = hit;
    r.writeback_needed = wb;
    r.writeback_block  = blk;
    r.last             = last;
    return r;
  endfunction

  task automatic predict_word(input in_word_t w);
    int               found;
    logic             wb;
    logic [BLK_W-1:0] blk;
    if (w.opcode == OP_FLUSH) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (line_valid[i] && line_dirty[i])
          expected_words.push_back(make_result(i, 1'b0, 1'b1, line_tag[i], 1'b0));
        line_valid[i] = 1'b0;
        line_dirty[i] = 1'b0;
      end
      expected_words.push_back(make_result(0, 1'b0, 1'b0, '0, 1'b1));
    end else begin
      found = -1;
      for (int i = 0; i < ENTRIES; i++)
        if (found < 0 && line_valid[i] && line_tag[i] == w.block_number)
          found = i;
      if (found >= 0) begin
        if (w.is_write)
          line_dirty[found] = 1'b1;
        expected_words.push_back(make_result(found, 1'b1, 1'b0, '0, 1'b1));
      end else begin
        wb  = 1'b0;
        blk = '0;
        for (int i = 0; i < ENTRIES; i++)
          if (found < 0 && !line_valid[i])
            found = i;
        // no free slot: round-robin eviction
        if (found < 0) begin
          found = evict_ptr;
          if (line_dirty[found]) begin
            wb  = 1'b1;
            blk = line_tag[found];
          end
          evict_ptr = (found + 1) % ENTRIES;
        end
        line_valid[found] = 1'b1;
        line_tag[found]   = w.block_number;
        line_dirty[found] = w.is_write;
        expected_words.push_back(make_result(found, 1'b0, wb, blk, 1'b1));
      end
    end
  endtask

  task automatic report_error(string what, out_word_t exp_w, out_word_t got_w);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s exp slot=%0d hit=%0b wb=%0b blk=%08h last=%0b",
               $time, what, exp_w.slot, exp_w.hit, exp_w.writeback_needed,
               exp_w.writeback_block, exp_w.last,
               "\n    got slot=%0d hit=%0b wb=%0b blk=%08h last=%0b",
               got_w.slot, got_w.hit, got_w.writeback_needed,
               got_w.writeback_block, got_w.last);
  endtask

  always @(posedge clk) begin
    out_word_t exp_w;
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++) begin
        line_valid[i] = 1'b0;
        line_dirty[i] = 1'b0;
        line_tag[i]   = '0;
      end
      evict_ptr = 0;
      expected_words.delete();
    end else begin
      if (out_valid) begin
        if (expected_words.size() == 0) begin
          report_error("unexpected word", '0, out_word);
        end else begin
          exp_w = expected_words.pop_front();
          if (out_word.slot !== exp_w.slot || out_word.hit !== exp_w.hit ||
              out_word.writeback_needed !== exp_w.writeback_needed ||
              out_word.writeback_block !== exp_w.writeback_block ||
              out_word.last !== exp_w.last)
            report_error("mismatch", exp_w, out_word);
        end
      end
      if (start && !busy)
        predict_word(in_word);
    end
    outstanding <= expected_words.size();
  end

endmodule

### dv/block_cache_slot_manager_core_tb.sv
// testbench top for block_cache_slot_manager_core: drives directed and random lookups
// and flushes with random gaps; checking is done by bcsm_slot_checker (needs bcsm_pkg)
`timescale 1ns / 1ps

module block_cache_slot_manager_core_tb;
  import bcsm_pkg::*;

  localparam int ITEMS = 450;
  localparam int LIMIT = 200000;
  localparam int DRAIN = ENTRIES + 8;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  in_word_t  in_word = '0;
  logic      busy;
  logic      out_valid;
  out_word_t out_word;
  int        mismatches;
  int        outstanding;
  int        cycles = 0;
  int        sent = 0;
  int        burst_left = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  block_cache_slot_manager_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_word   (in_word),
    .busy      (busy),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

  bcsm_slot_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_word     (in_word),
    .out_valid   (out_valid),
    .out_word    (out_word),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("block_cache_slot_manager_core_tb NOT OK");
      $finish;
    end
  end

  function automatic in_word_t make_word(op_t op, logic [BLK_W-1:0] blk, logic wr);
    in_word_t w;
    w.opcode       = op;
    w.block_number = blk;
    w.is_write     = wr;
    return w;
  endfunction

  task automatic send_word(input in_word_t w);
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else if ($urandom_range(0, 7) == 0) begin
      burst_left = $urandom_range(5, 25);
      gap = 0;
    end else begin
      gap = $urandom_range(0, 14);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (busy);
    sent++;
  endtask

  initial begin
    logic [BLK_W-1:0] base;
    int               pool;
    int               wr_pct;
    int               seg_len;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty flush, extremes, hits, dirty reports, ignored fields
    send_word(make_word(OP_FLUSH, 32'h0000_0000, 1'b0));
    send_word(make_word(OP_LOOKUP, 32'h0000_0000, 1'b0));
    send_word(make_word(OP_LOOKUP, 32'hFFFF_FFFF, 1'b1));
    send_word(make_word(OP_LOOKUP, 32'h0000_0000, 1'b0));
    send_word(make_word(OP_LOOKUP, 32'h0000_0000, 1'b1));
    send_word(make_word(OP_LOOKUP, 32'hFFFF_FFFF, 1'b0));
    send_word(make_word(OP_LOOKUP, 32'hAAAA_AAAA, 1'b1));
    send_word(make_word(OP_LOOKUP, 32'h5555_5555, 1'b0));
    send_word(make_word(OP_FLUSH, 32'h0000_0000, 1'b1));
    send_word(make_word(OP_FLUSH, 32'hFFFF_FFFF, 1'b1));
    send_word(make_word(OP_LOOKUP, 32'h5555_5555, 1'b1));
    send_word(make_word(OP_LOOKUP, 32'h0000_0001, 1'b0));

    // random: segments over a block pool, mostly closed by a flush
    while (sent < ITEMS) begin
      base    = $urandom();
      pool    = 8 << $urandom_range(0, 3);
      wr_pct  = 50 * $urandom_range(0, 2);
      seg_len = $urandom_range(20, 60);
      for (int k = 0; k < seg_len && sent < ITEMS; k++) begin
        if ($urandom_range(0, 99) < 3)
          send_word(make_word(OP_FLUSH, $urandom(), 1'($urandom_range(0, 1))));
        else
          send_word(make_word(OP_LOOKUP, base + $urandom_range(0, pool - 1),
                              $urandom_range(0, 99) < wr_pct));
      end
      if ($urandom_range(0, 9) != 0)
        send_word(make_word(OP_FLUSH, $urandom(), 1'($urandom_range(0, 1))));
    end
    start <= 1'b0;

    do @(negedge clk); while (outstanding != 0);
    repeat (DRAIN) @(negedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("block_cache_slot_manager_core_tb OK");
    else
      $display("block_cache_slot_manager_core_tb NOT OK");
    $finish;
  end

endmodule
